// ===== rtl/multi_voice_saturating_mixer_assert.svh =====
// Assertion macros shared by the mixer RTL.
// All three sample on clk and stand down while arst_n is low.
`ifndef MULTI_VOICE_SATURATING_MIXER_ASSERT_SVH
`define MULTI_VOICE_SATURATING_MIXER_ASSERT_SVH

// Plain property check.
`define MVSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MVSM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mvsm_pkg.sv =====
package mvsm_pkg;

	localparam int VOICES_DEF  = 4;
	localparam int SAMPLE_W    = 16;
	localparam int LENGTH_W    = 24;
	localparam int REMAIN_W    = 32;
	localparam int BLOCK_LEN_W = 13;
	localparam int POS_W       = 12;
	localparam int SLOT_W      = 3;
	localparam int MASK_W      = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;

	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 13'd512;
	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_MAX   = 13'd4096;
	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_MIN   = 13'd1;

	localparam int OFFSET_8BIT = 128;
	localparam int CLAMP_8_HI  = 255;
	localparam int CLAMP_16_HI = 32767;
	localparam int CLAMP_16_LO = -32767;

	localparam logic [CFG_INDEX_W-1:0] REG_SIXTEEN_BIT_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH     = 1'd1;

	localparam logic FUNC_MIX   = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef struct packed {
		logic                mix;
		logic                start;
		logic                mode16;
		logic                block_end;
		logic [LENGTH_W-1:0] length;
		logic                loop;
	} mvsm_lane_ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mixed_sample;
		logic [SLOT_W-1:0]          slot_index;
		logic [MASK_W-1:0]          active_mask;
		logic                       block_done;
	} mvsm_result_t;

endpackage

// ===== rtl/mvsm_lane.sv =====
module mvsm_lane import mvsm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mvsm_lane_ctl_t             ctl,
	input  logic                       claim,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       active,
	output logic                       active_next,
	output logic signed [SAMPLE_W-1:0] contrib
);

	logic                active_q;
	logic [REMAIN_W-1:0] remain_q;
	logic [LENGTH_W-1:0] reload_q;
	logic                loop_q;

	logic                active_d;
	logic [REMAIN_W-1:0] remain_d;
	logic [LENGTH_W-1:0] reload_d;
	logic                loop_d;

	always_comb begin
		active_d = active_q;
		remain_d = remain_q;
		reload_d = reload_q;
		loop_d   = loop_q;
		contrib  = '0;
		if (ctl.start && claim) begin
			active_d = 1'b1;
			remain_d = {{(REMAIN_W-LENGTH_W){1'b0}}, ctl.length};
			reload_d = ctl.length;
			loop_d   = ctl.loop;
		end
		if (ctl.mix) begin
			if (active_q) begin
				if (ctl.mode16) begin
					contrib  = sample;
					remain_d = remain_q - REMAIN_W'(2);
					active_d = !(remain_d == '0 || remain_d[REMAIN_W-1]);
				end else begin
					contrib  = {{(SAMPLE_W-8){sample[7]}}, sample[7:0]};
					active_d = (remain_q != '0);
					remain_d = remain_q - REMAIN_W'(1);
				end
			end
			if (ctl.block_end && loop_q && (remain_d == '0 || remain_d[REMAIN_W-1])) begin
				remain_d = {{(REMAIN_W-LENGTH_W){1'b0}}, reload_q};
				active_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			remain_q <= '0;
			reload_q <= '0;
			loop_q   <= 1'b0;
		end else begin
			active_q <= active_d;
			remain_q <= remain_d;
			reload_q <= reload_d;
			loop_q   <= loop_d;
		end
	end

	assign active      = active_q;
	assign active_next = active_d;

endmodule

// ===== rtl/mvsm_merge.sv =====
module mvsm_merge import mvsm_pkg::*; #(
	parameter int Voices = VOICES_DEF
) (
	input  logic                       mode16,
	input  logic signed [SAMPLE_W-1:0] contrib [Voices],
	output logic signed [SAMPLE_W-1:0] mixed
);

	localparam int SumW = SAMPLE_W + 2 + $clog2(Voices);

	logic signed [SumW-1:0] sum;

	always_comb begin
		sum = mode16 ? SumW'(0) : SumW'(OFFSET_8BIT);
		for (int v = 0; v < Voices; v++) begin
			sum = sum + SumW'(contrib[v]);
		end
		if (mode16) begin
			if (sum > SumW'(CLAMP_16_HI))
				mixed = SAMPLE_W'(CLAMP_16_HI);
			else if (sum < SumW'(CLAMP_16_LO))
				mixed = SAMPLE_W'(CLAMP_16_LO);
			else
				mixed = sum[SAMPLE_W-1:0];
		end else begin
			if (sum > SumW'(CLAMP_8_HI))
				mixed = SAMPLE_W'(CLAMP_8_HI);
			else if (sum < SumW'(0))
				mixed = '0;
			else
				mixed = sum[SAMPLE_W-1:0];
		end
	end

endmodule

// ===== rtl/multi_voice_saturating_mixer.sv =====
// Multi-voice saturating mixer.
// Input channel (in_valid / in_stall): one transaction per item. func selects a
// mix (one sample per voice summed over the active voices) or a voice start
// (claims the lowest free slot with voice_length and voice_loop).
// Output channel (out_valid / out_stall): exactly one result per item, in order.
// Configuration: cfg_write with cfg_index / cfg_data, only while the block is idle.
// An accepted result is registered, in the skid register if the output is stalled.
// Throughput: one item per cycle while in_stall is low; all voice lanes update in
// parallel in the accept cycle and an adder chain plus clamp merges their samples.
// Stall: a two-entry output buffer (output register plus skid register) lets
// one item be accepted while a result is stalled; in_stall rises only when
// both entries are full and falls after the receiver takes a result.
// Reset (arst_n low): all voices inactive with zero counters, block position
// zero, 8-bit mode, block length 512, output buffer empty.
`include "multi_voice_saturating_mixer_assert.svh"

module multi_voice_saturating_mixer import mvsm_pkg::*; #(
	parameter int Voices = VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic signed [SAMPLE_W-1:0]    voice_sample_0,
	input  logic signed [SAMPLE_W-1:0]    voice_sample_1,
	input  logic signed [SAMPLE_W-1:0]    voice_sample_2,
	input  logic signed [SAMPLE_W-1:0]    voice_sample_3,
	input  logic [LENGTH_W-1:0]           voice_length,
	input  logic                          voice_loop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_W-1:0]    mixed_sample,
	output logic [SLOT_W-1:0]             slot_index,
	output logic [MASK_W-1:0]             active_mask,
	output logic                          block_done
);

	localparam int SlotW = $clog2(Voices + 1);

	logic                   mode16_q;
	logic [BLOCK_LEN_W-1:0] block_len_q;
	logic [POS_W-1:0]       pos_q;

	logic                   accept;
	logic                   is_mix;
	logic                   is_start;
	logic [BLOCK_LEN_W-1:0] eff_len;
	logic [BLOCK_LEN_W-1:0] count;
	logic                   block_end;
	logic [SlotW-1:0]       slot;
	logic [Voices-1:0]      claim;
	logic [Voices-1:0]      act;
	logic [Voices-1:0]      act_next;
	logic [MASK_W-1:0]      mask;
	logic signed [SAMPLE_W-1:0] samples [Voices];
	logic signed [SAMPLE_W-1:0] contrib [Voices];
	logic signed [SAMPLE_W-1:0] mixed;
	mvsm_lane_ctl_t         lane_ctl;
	mvsm_result_t           res;

	logic         out_valid_q;
	logic         skid_valid_q;
	mvsm_result_t out_q;
	mvsm_result_t skid_q;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign is_mix   = accept && (func == FUNC_MIX);
	assign is_start = accept && (func == FUNC_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode16_q    <= 1'b0;
			block_len_q <= BLOCK_LEN_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SIXTEEN_BIT_MODE: mode16_q    <= cfg_data[0];
				REG_BLOCK_LENGTH:     block_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (block_len_q == '0)
			eff_len = BLOCK_LEN_MIN;
		else if (block_len_q > BLOCK_LEN_MAX)
			eff_len = BLOCK_LEN_MAX;
		else
			eff_len = block_len_q;
		count     = {1'b0, pos_q} + BLOCK_LEN_W'(1);
		block_end = is_mix && (count >= eff_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (is_mix) begin
			pos_q <= block_end ? '0 : count[POS_W-1:0];
		end
	end

	// lowest free slot
	always_comb begin
		slot  = SlotW'(Voices);
		claim = '0;
		for (int v = Voices - 1; v >= 0; v--) begin
			if (!act[v])
				slot = SlotW'(v);
		end
		for (int v = 0; v < Voices; v++) begin
			claim[v] = (slot == SlotW'(v));
		end
	end

	always_comb begin
		for (int v = 0; v < Voices; v++) begin
			case (v)
				0:       samples[v] = voice_sample_0;
				1:       samples[v] = voice_sample_1;
				2:       samples[v] = voice_sample_2;
				3:       samples[v] = voice_sample_3;
				default: samples[v] = '0;
			endcase
		end
	end

	assign lane_ctl.mix       = is_mix;
	assign lane_ctl.start     = is_start;
	assign lane_ctl.mode16    = mode16_q;
	assign lane_ctl.block_end = block_end;
	assign lane_ctl.length    = voice_length;
	assign lane_ctl.loop      = voice_loop;

	for (genvar g = 0; g < Voices; g++) begin : g_lane
		mvsm_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl),
			.claim      (claim[g]),
			.sample     (samples[g]),
			.active     (act[g]),
			.active_next(act_next[g]),
			.contrib    (contrib[g])
		);
	end

	mvsm_merge #(
		.Voices(Voices)
	) u_merge (
		.mode16 (mode16_q),
		.contrib(contrib),
		.mixed  (mixed)
	);

	always_comb begin
		mask = '0;
		for (int v = 0; v < Voices && v < MASK_W; v++) begin
			mask[v] = act_next[v];
		end
		res.mixed_sample = is_start ? '0 : mixed;
		res.slot_index   = is_start ? SLOT_W'(slot) : '0;
		res.active_mask  = mask;
		res.block_done   = block_end;
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_valid_q && out_stall)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && out_stall)
				skid_q <= res;
			else
				out_q <= res;
		end else if (out_valid_q && !out_stall && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = out_q.mixed_sample;
	assign slot_index   = out_q.slot_index;
	assign active_mask  = out_q.active_mask;
	assign block_done   = out_q.block_done;

	`MVSM_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without output entry")
	`MVSM_ASSERT(a_single_claim, $onehot0(claim), "more than one lane claimed")
	`MVSM_ASSERT_IMPL(a_done_on_mix, block_end, is_mix && !is_start, "block end outside a mix")
	`MVSM_ASSERT_NEXT(a_start_fills, is_start, &(act | ~$past(claim)), "claimed voice not active")

endmodule
